// File: design/sca_pkg.sv
// shared types, constants and the size-to-class map of the size class pool allocator
package sca_pkg;

  localparam int NUM_CLASSES = 76;
  localparam int CLASS_W     = 7;
  localparam int SLOT_W      = 8;
  localparam int SIZE_W      = 32;
  localparam int SMALL_W     = 13;   // wide enough for any size up to the 4 KB limit
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  // size breakpoints of the class map
  localparam int SZ_LIMIT_4K = 1024 * 4;
  localparam int SZ_LIMIT_1K = 1024;
  localparam int SZ_2K       = 2048;
  localparam int SZ_512      = 512;
  localparam int SZ_256      = 256;
  localparam int SZ_128      = 128;
  localparam int SZ_32       = 32;

  // first class of each step band
  localparam int BASE_128B   = 60;
  localparam int BASE_64B    = 36;
  localparam int BASE_32B    = 28;
  localparam int BASE_16B    = 20;
  localparam int BASE_8B     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_4KB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PTR_8B    = 1'b1;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_OOM       = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  // piecewise-linear size to class map, size in 1..4096
  function automatic logic [CLASS_W-1:0] class_of(input logic [SMALL_W-1:0] s,
                                                  input logic ptr8);
    logic [SMALL_W-1:0] c;
    logic [SMALL_W-1:0] ptr_sz;
    ptr_sz = ptr8 ? SMALL_W'(8) : SMALL_W'(4);
    if (s <= SMALL_W'(SZ_32)) begin
      if (s <= ptr_sz) begin
        c = ptr8 ? SMALL_W'(1) : SMALL_W'(0);
      end else begin
        c = (s - SMALL_W'(1)) >> 2;
      end
    end else if (s <= SMALL_W'(SZ_128)) begin
      c = SMALL_W'(BASE_8B) + ((s - SMALL_W'(SZ_32 + 1)) >> 3);
    end else if (s <= SMALL_W'(SZ_256)) begin
      c = SMALL_W'(BASE_16B) + ((s - SMALL_W'(SZ_128 + 1)) >> 4);
    end else if (s <= SMALL_W'(SZ_512)) begin
      c = SMALL_W'(BASE_32B) + ((s - SMALL_W'(SZ_256 + 1)) >> 5);
    end else if (s <= SMALL_W'(SZ_2K)) begin
      c = SMALL_W'(BASE_64B) + ((s - SMALL_W'(SZ_512 + 1)) >> 6);
    end else begin
      c = SMALL_W'(BASE_128B) + ((s - SMALL_W'(SZ_2K + 1)) >> 7);
    end
    if (c > SMALL_W'(NUM_CLASSES - 1)) begin
      c = SMALL_W'(NUM_CLASSES - 1);
    end
    return c[CLASS_W-1:0];
  endfunction

endpackage

// File: design/sca_if.sv
// request and result channel interfaces of the size class pool allocator
interface sca_in_if;
  import sca_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] size_bytes;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, mode, size_bytes, slot_in, input ready);
  modport sink   (input valid, mode, size_bytes, slot_in, output ready);
endinterface

interface sca_out_if;
  import sca_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [CLASS_W-1:0] class_index;
  logic [SLOT_W-1:0]  slot_out;

  modport source (output valid, status, class_index, slot_out, input ready);
  modport sink   (input valid, status, class_index, slot_out, output ready);
endinterface

// File: design/sca_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sca_class_store.sv
// per-class head / free count / bump count store with reset-cleared valid bits
module sca_class_store #(
  parameter int CNT_W = 9
) (
  input  logic clk,
  input  logic rst_n,
  input  logic rd_en,
  input  logic [sca_pkg::CLASS_W-1:0] rd_addr,
  output logic [sca_pkg::SLOT_W-1:0]  rd_head,
  output logic [CNT_W-1:0]            rd_fcnt,
  output logic [CNT_W-1:0]            rd_bcnt,
  input  logic wr_en,
  input  logic [sca_pkg::CLASS_W-1:0] wr_addr,
  input  logic [sca_pkg::SLOT_W-1:0]  wr_head,
  input  logic [CNT_W-1:0]            wr_fcnt,
  input  logic [CNT_W-1:0]            wr_bcnt
);
  import sca_pkg::*;

  localparam int ENT_W = SLOT_W + 2 * CNT_W;

  logic [NUM_CLASSES-1:0] vld_r;
  logic                   rd_vld_r;
  logic [ENT_W-1:0]       rdata;

  sca_ram #(.WIDTH(ENT_W), .DEPTH(NUM_CLASSES)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({wr_head, wr_fcnt, wr_bcnt}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written classes read as empty
  assign rd_head = rd_vld_r ? rdata[ENT_W-1 -: SLOT_W] : '0;
  assign rd_fcnt = rd_vld_r ? rdata[2*CNT_W-1 -: CNT_W] : '0;
  assign rd_bcnt = rd_vld_r ? rdata[CNT_W-1:0] : '0;

endmodule

// File: design/size_class_pool_allocator.sv
// top level of the size class pool allocator: request sequencer, class store and link memory
//
//  channel  dir  handshake            word
//  in_ch    in   valid/ready          mode, size_bytes, slot_in
//  out_ch   out  valid/ready          status, class_index, slot_out
//  cfg      in   cfg_we (no stall)    cfg_index, cfg_wdata
//
// a free-list pop allocate passes S_IDLE, S_LOOK, S_POP; every other request S_IDLE, S_LOOK:
//   the accept cycle reads the class entry, S_LOOK decides and writes back,
//   a pop reads the next link in S_LOOK and writes it back as the class head in S_POP
// one request is in flight at a time; the next is taken once write-back is done
// the result register lets a finished word wait while the next request is taken;
//   a new result stalls in its decide / pop cycle until that register frees up
// synchronous active-low reset clears control state and class valid bits; no clearing pass
module size_class_pool_allocator #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sca_in_if.sink                       in_ch,
  sca_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sca_pkg::*;

  // count width holds SLOTS_PER_CLASS itself
  localparam int CNT_W      = $clog2(SLOTS_PER_CLASS + 1);
  // freed slots come from an 8-bit field, so each class needs at most 256 link rows
  localparam int LS_W       = (SLOTS_PER_CLASS >= 256) ? SLOT_W : $clog2(SLOTS_PER_CLASS);
  localparam int LINK_DEPTH = NUM_CLASSES * (1 << LS_W);
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int EXT_W      = CNT_W + SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic limit_4k_r;
  logic ptr8_r;

  // request held across its cycles
  logic               mode_r, mode_nxt;
  logic [SLOT_W-1:0]  slot_in_r, slot_in_nxt;
  logic [CLASS_W-1:0] cls_r, cls_nxt;
  status_t            pre_st_r, pre_st_nxt;
  logic [SLOT_W-1:0]  pop_slot_r, pop_slot_nxt;
  logic [CNT_W-1:0]   pop_fcnt_r, pop_fcnt_nxt;
  logic [CNT_W-1:0]   pop_bcnt_r, pop_bcnt_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [CLASS_W-1:0] out_class_r, out_class_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;

  // accept-cycle decode
  logic               accept;
  logic [SIZE_W-1:0]  limit;
  status_t            acc_st;
  logic [CLASS_W-1:0] acc_cls;

  // class store
  logic [SLOT_W-1:0]  cs_head;
  logic [CNT_W-1:0]   cs_fcnt;
  logic [CNT_W-1:0]   cs_bcnt;
  logic               cs_we;
  logic [SLOT_W-1:0]  cs_wr_head;
  logic [CNT_W-1:0]   cs_wr_fcnt;
  logic [CNT_W-1:0]   cs_wr_bcnt;

  // link memory
  logic               lk_we;
  logic               lk_re;
  logic [LINK_AW-1:0] lk_waddr;
  logic [LINK_AW-1:0] lk_raddr;
  logic [SLOT_W-1:0]  lk_wdata;
  logic [SLOT_W-1:0]  lk_rdata;

  logic               out_free;
  logic [EXT_W-1:0]   bcnt_ext;
  logic               slot_bad;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.class_index = out_class_r;
  assign out_ch.slot_out    = out_slot_r;

  // pre-check and class map straight off the input word
  always_comb begin
    limit   = limit_4k_r ? SIZE_W'(SZ_LIMIT_4K) : SIZE_W'(SZ_LIMIT_1K);
    acc_st  = ST_OK;
    acc_cls = '0;
    if (in_ch.size_bytes == '0) begin
      acc_st = ST_INVALID;
    end else if (in_ch.size_bytes > limit) begin
      acc_st = ST_TOO_LARGE;
    end else begin
      acc_cls = class_of(in_ch.size_bytes[SMALL_W-1:0], ptr8_r);
    end
  end

  sca_class_store #(.CNT_W(CNT_W)) u_class_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (acc_cls),
    .rd_head (cs_head),
    .rd_fcnt (cs_fcnt),
    .rd_bcnt (cs_bcnt),
    .wr_en   (cs_we),
    .wr_addr (cls_r),
    .wr_head (cs_wr_head),
    .wr_fcnt (cs_wr_fcnt),
    .wr_bcnt (cs_wr_bcnt)
  );

  sca_ram #(.WIDTH(SLOT_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  assign lk_waddr = {cls_r, slot_in_r[LS_W-1:0]};
  assign lk_raddr = {cls_r, cs_head[LS_W-1:0]};
  assign bcnt_ext = {{SLOT_W{1'b0}}, cs_bcnt};
  // slot numbers at or past the region size are rejected
  assign slot_bad = {{CNT_W{1'b0}}, slot_in_r} >= EXT_W'(SLOTS_PER_CLASS);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    slot_in_nxt    = slot_in_r;
    cls_nxt        = cls_r;
    pre_st_nxt     = pre_st_r;
    pop_slot_nxt   = pop_slot_r;
    pop_fcnt_nxt   = pop_fcnt_r;
    pop_bcnt_nxt   = pop_bcnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_class_nxt  = out_class_r;
    out_slot_nxt   = out_slot_r;
    cs_we          = 1'b0;
    cs_wr_head     = cs_head;
    cs_wr_fcnt     = cs_fcnt;
    cs_wr_bcnt     = cs_bcnt;
    lk_we          = 1'b0;
    lk_re          = 1'b0;
    lk_wdata       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = in_ch.mode;
          slot_in_nxt = in_ch.slot_in;
          cls_nxt     = acc_cls;
          pre_st_nxt  = acc_st;
          state_nxt   = S_LOOK;
        end
      end

      S_LOOK: begin
        if (out_free) begin
          out_class_nxt = cls_r;
          out_slot_nxt  = '0;
          state_nxt     = S_IDLE;
          if (pre_st_r != ST_OK) begin
            // zero size or oversize: no state change
            out_valid_nxt  = 1'b1;
            out_status_nxt = pre_st_r;
          end else if (mode_r == MODE_ALLOC) begin
            if (cs_fcnt != '0) begin
              // pop: fetch the next link before writing the class back
              lk_re         = 1'b1;
              pop_slot_nxt  = cs_head;
              pop_fcnt_nxt  = cs_fcnt - CNT_W'(1);
              pop_bcnt_nxt  = cs_bcnt;
              state_nxt     = S_POP;
            end else if (cs_bcnt < CNT_W'(SLOTS_PER_CLASS)) begin
              cs_we          = 1'b1;
              cs_wr_bcnt     = cs_bcnt + CNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_slot_nxt   = bcnt_ext[SLOT_W-1:0];
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OOM;
            end
          end else begin
            if (slot_bad || (cs_fcnt >= CNT_W'(SLOTS_PER_CLASS))) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INVALID;
            end else begin
              // push: old head becomes the link of the freed slot
              lk_we          = 1'b1;
              lk_wdata       = (cs_fcnt != '0) ? cs_head : '0;
              cs_we          = 1'b1;
              cs_wr_head     = slot_in_r;
              cs_wr_fcnt     = cs_fcnt + CNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
          end
        end
      end

      S_POP: begin
        if (out_free) begin
          cs_we          = 1'b1;
          cs_wr_head     = lk_rdata;
          cs_wr_fcnt     = pop_fcnt_r;
          cs_wr_bcnt     = pop_bcnt_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_class_nxt  = cls_r;
          out_slot_nxt   = pop_slot_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_4k_r  <= 1'b1;
      ptr8_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMIT_4KB: limit_4k_r <= cfg_wdata[0];
          CFG_PTR_8B:    ptr8_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    mode_r       <= mode_nxt;
    slot_in_r    <= slot_in_nxt;
    cls_r        <= cls_nxt;
    pre_st_r     <= pre_st_nxt;
    pop_slot_r   <= pop_slot_nxt;
    pop_fcnt_r   <= pop_fcnt_nxt;
    pop_bcnt_r   <= pop_bcnt_nxt;
    out_status_r <= out_status_nxt;
    out_class_r  <= out_class_nxt;
    out_slot_r   <= out_slot_nxt;
  end

endmodule
